FILE: sv/u8e_pkg.sv
`default_nettype none

package u8e_pkg;

    localparam int unsigned ACCUM_W   = 31;
    localparam int unsigned RUN_LEN_W = 4;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_U         = 8'h75;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_NINE      = 8'h39;
    localparam logic [7:0] CHAR_A_LOWER   = 8'h61;
    localparam logic [7:0] CHAR_F_LOWER   = 8'h66;

    localparam logic [RUN_LEN_W-1:0] RUN_LEN_RAW   = 4'd1;
    localparam logic [RUN_LEN_W-1:0] RUN_LEN_HEX4  = 4'd6;
    localparam logic [RUN_LEN_W-1:0] RUN_LEN_HEX6  = 4'd8;
    localparam logic [RUN_LEN_W-1:0] RUN_LEN_HEX8  = 4'd10;

    localparam logic ESCAPE_ENABLE_RESET = 1'b1;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } text_beat_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_run;
        logic       malformed;
    } char_beat_t;

    typedef struct packed {
        logic [2:0]         bytes_remaining;
        logic [2:0]         sequence_length;
        logic [ACCUM_W-1:0] code_point_accum;
        logic               bad_continuation_seen;
    } seq_state_t;

    typedef struct packed {
        logic                 escape;
        logic [ACCUM_W-1:0]   code;
        logic [RUN_LEN_W-1:0] run_len;
        logic                 malformed;
    } run_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ext;
        ext = {4'h0, nib};
        if (nib < 4'd10)
        begin
            hex_char = ext + CHAR_ZERO;
        end
        else
        begin
            hex_char = ext + (CHAR_A_LOWER - 8'd10);
        end
    endfunction

endpackage

`default_nettype wire

FILE: sv/utf8_to_unicode_escape_unit.sv
// A text beat that yields chars loads the run register; its first char beat
// is then registered in the output register. Throughput: one text beat per
// cycle for passed-through bytes unless char_stall holds the output; an escape
// emits 6, 8 or 10 char beats from the run register while text stalls. Bytes
// in a sequence before its last emit nothing. Reset (rst_n low,
// asynchronous): sequence state idle, no pending chars, escape_enable set.
`default_nettype none

module utf8_to_unicode_escape_unit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 text_valid,
    output logic                      text_stall,
    input  wire u8e_pkg::text_beat_t  text_beat,
    output logic                      char_valid,
    input  wire logic                 char_stall,
    output u8e_pkg::char_beat_t       char_beat,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic                 cfg_data
);

    logic                  enable_reg, enable_next;
    u8e_pkg::seq_state_t   state_reg, state_next, dec_state;
    logic                  dec_run_valid;
    u8e_pkg::run_t         dec_run;
    logic                  load_ok;
    logic                  accept;

    assign cfg_ready   = 1'b1;
    assign enable_next = (cfg_valid && cfg_ready) ? cfg_data : enable_reg;
    assign text_stall  = !load_ok;
    assign accept      = text_valid && load_ok;
    assign state_next  = accept ? dec_state : state_reg;

    u8e_decode u_decode (
        .enable     (enable_reg),
        .state      (state_reg),
        .beat       (text_beat),
        .state_next (dec_state),
        .run_valid  (dec_run_valid),
        .run        (dec_run)
    );

    u8e_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept && dec_run_valid),
        .run_in     (dec_run),
        .load_ok    (load_ok),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_beat  (char_beat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= u8e_pkg::ESCAPE_ENABLE_RESET;
            state_reg  <= '0;
        end
        else
        begin
            enable_reg <= enable_next;
            state_reg  <= state_next;
        end
    end

    a_eot_idle: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !text_stall && text_beat.end_of_text
        |=> state_reg.bytes_remaining == 3'd0)
        else $error("sequence state not idle after end of text");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_stall && !char_beat.last_of_run |=> char_valid)
        else $error("escape run broken before its last char");

    a_escape_chars: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_beat.last_of_run
        |-> (char_beat.out_char == u8e_pkg::CHAR_BACKSLASH)
            || (char_beat.out_char == u8e_pkg::CHAR_U)
            || ((char_beat.out_char >= u8e_pkg::CHAR_ZERO)
                && (char_beat.out_char <= u8e_pkg::CHAR_NINE))
            || ((char_beat.out_char >= u8e_pkg::CHAR_A_LOWER)
                && (char_beat.out_char <= u8e_pkg::CHAR_F_LOWER)))
        else $error("non-final char of a run is not an escape char");

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        text_stall |-> char_valid || $past(text_valid && !text_stall))
        else $error("text stalled with no run pending");

endmodule

`default_nettype wire

FILE: sv/u8e_decode.sv
`default_nettype none

module u8e_decode (
    input  wire logic               enable,
    input  wire u8e_pkg::seq_state_t state,
    input  wire u8e_pkg::text_beat_t beat,
    output u8e_pkg::seq_state_t      state_next,
    output logic                     run_valid,
    output u8e_pkg::run_t            run
);

    always_comb
    begin
        logic [7:0]                     b;
        logic [2:0]                     len;
        logic [u8e_pkg::ACCUM_W-1:0]    init;
        logic [u8e_pkg::ACCUM_W-1:0]    acc;
        logic [2:0]                     rem;
        logic                           bad;
        logic                           lead;

        b          = beat.text_byte;
        len        = 3'd0;
        init       = '0;
        lead       = 1'b1;
        acc        = {state.code_point_accum[u8e_pkg::ACCUM_W-7:0], b[5:0]};
        rem        = state.bytes_remaining - 3'd1;
        bad        = state.bad_continuation_seen | (b[7:6] != 2'b10);
        state_next = state;
        run_valid  = 1'b0;
        run        = '0;

        if (b[7:5] == 3'b110)
        begin
            len  = 3'd2;
            init = u8e_pkg::ACCUM_W'(b[4:0]);
        end
        else if (b[7:4] == 4'b1110)
        begin
            len  = 3'd3;
            init = u8e_pkg::ACCUM_W'(b[3:0]);
        end
        else if (b[7:3] == 5'b11110)
        begin
            len  = 3'd4;
            init = u8e_pkg::ACCUM_W'(b[2:0]);
        end
        else if (b[7:2] == 6'b111110)
        begin
            len  = 3'd5;
            init = u8e_pkg::ACCUM_W'(b[1:0]);
        end
        else if (b[7:1] == 7'b1111110)
        begin
            len  = 3'd6;
            init = u8e_pkg::ACCUM_W'(b[0]);
        end
        else
        begin
            lead = 1'b0;
        end

        if (!enable)
        begin
            state_next = '0;
            run_valid  = 1'b1;
            run.code   = u8e_pkg::ACCUM_W'(b);
            run.run_len = u8e_pkg::RUN_LEN_RAW;
        end
        else if (state.bytes_remaining == 3'd0)
        begin
            if (!lead)
            begin
                run_valid   = 1'b1;
                run.code    = u8e_pkg::ACCUM_W'(b);
                run.run_len = u8e_pkg::RUN_LEN_RAW;
            end
            else if (beat.end_of_text)
            begin
                state_next = '0;
            end
            else
            begin
                state_next.bytes_remaining       = len - 3'd1;
                state_next.sequence_length       = len;
                state_next.code_point_accum      = init;
                state_next.bad_continuation_seen = 1'b0;
            end
        end
        else if (rem != 3'd0)
        begin
            if (beat.end_of_text)
            begin
                state_next = '0;
            end
            else
            begin
                state_next.bytes_remaining       = rem;
                state_next.code_point_accum      = acc;
                state_next.bad_continuation_seen = bad;
            end
        end
        else
        begin
            state_next    = '0;
            run_valid     = 1'b1;
            run.escape    = 1'b1;
            run.code      = acc;
            run.malformed = bad;
            if (state.sequence_length <= 3'd3)
            begin
                run.run_len = u8e_pkg::RUN_LEN_HEX4;
            end
            else if (state.sequence_length == 3'd4)
            begin
                run.run_len = u8e_pkg::RUN_LEN_HEX6;
            end
            else
            begin
                run.run_len = u8e_pkg::RUN_LEN_HEX8;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/u8e_emit.sv
`default_nettype none

module u8e_emit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire u8e_pkg::run_t       run_in,
    output logic                     load_ok,
    output logic                     char_valid,
    input  wire logic                char_stall,
    output u8e_pkg::char_beat_t      char_beat
);

    logic                              run_valid_reg, run_valid_next;
    u8e_pkg::run_t                     run_reg, run_next;
    logic [u8e_pkg::RUN_LEN_W-1:0]     idx_reg, idx_next;
    logic                              out_valid_reg, out_valid_next;
    u8e_pkg::char_beat_t               out_reg, out_next;

    logic                              out_free;
    logic                              advance;
    logic                              run_last;
    logic [u8e_pkg::RUN_LEN_W-1:0]     pos;
    logic [31:0]                       code_ext;
    logic [3:0]                        nib;
    logic [7:0]                        ch;

    assign out_free = !out_valid_reg || !char_stall;
    assign advance  = run_valid_reg && out_free;
    assign run_last = (idx_reg == (run_reg.run_len - u8e_pkg::RUN_LEN_W'(1)));
    assign load_ok  = !run_valid_reg || (advance && run_last);

    assign pos      = run_reg.run_len - u8e_pkg::RUN_LEN_W'(1) - idx_reg;
    assign code_ext = {1'b0, run_reg.code};
    assign nib      = code_ext[pos[2:0]*4 +: 4];

    always_comb
    begin
        if (!run_reg.escape)
        begin
            ch = run_reg.code[7:0];
        end
        else if (idx_reg == u8e_pkg::RUN_LEN_W'(0))
        begin
            ch = u8e_pkg::CHAR_BACKSLASH;
        end
        else if (idx_reg == u8e_pkg::RUN_LEN_W'(1))
        begin
            ch = u8e_pkg::CHAR_U;
        end
        else
        begin
            ch = u8e_pkg::hex_char(nib);
        end
    end

    always_comb
    begin
        run_valid_next = run_valid_reg;
        run_next       = run_reg;
        idx_next       = idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && char_stall;

        if (advance)
        begin
            out_valid_next        = 1'b1;
            out_next.out_char     = ch;
            out_next.last_of_run  = run_last;
            out_next.malformed    = run_reg.malformed;
            idx_next              = idx_reg + u8e_pkg::RUN_LEN_W'(1);
            if (run_last)
            begin
                run_valid_next = 1'b0;
            end
        end

        if (load)
        begin
            run_valid_next = 1'b1;
            run_next       = run_in;
            idx_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            run_valid_reg <= run_valid_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg <= run_next;
        out_reg <= out_next;
    end

    assign char_valid = out_valid_reg;
    assign char_beat  = out_reg;

endmodule

`default_nettype wire
